// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent check, sampled on the rising clock, off while reset is asserted.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/cb3_pkg.sv =====
`timescale 1ns / 1ps

package cb3_pkg;

    localparam int PIX_W       = 8;
    localparam int PX_W        = 2 * PIX_W;
    localparam int COORD_W     = 10;
    localparam int CFG_W       = COORD_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_WIDTH   = 1 << COORD_W;
    localparam int MAX_HEIGHT  = 1 << COORD_W;
    localparam int SUM_W       = PIX_W + 4;
    localparam int IN_TDATA_W  = PX_W;
    localparam int OUT_FIELD_W = PX_W + 2 * COORD_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_BLUR_ENABLE  = 2'd2,
        REG_BORDER_PLANE = 2'd3
    } t_reg_idx;

    // body in the low byte, border in the high byte
    typedef struct packed {
        logic [PIX_W-1:0] border;
        logic [PIX_W-1:0] body;
    } t_pixel;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last_col;
        logic               last_row;
        logic               blur;
        t_pixel             px;
    } t_stage;

    // zero counts as one, anything above the maximum saturates
    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] max_v);
        logic [CFG_W-1:0] res;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (v > max_v) begin
            res = max_v;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] plane_of(input t_pixel p, input logic border);
        return border ? p.border : p.body;
    endfunction

endpackage

// ===== design/coverage_blur_3x3.sv =====
// Path: an accepted pixel is registered in stage 1, and its results then in the output
//   register; stage 1 holds the pixel while that register still has results not yet taken.
// Throughput: one pixel per cycle unless stalled; a pixel that releases k results (up to 2
//   at the last column or in the last row, up to 4 at the last pixel of a frame) holds the
//   single output register until all k are taken; the next pixel waits in stage 1 meanwhile.
// Line store: two 1024 x 16 row memories, both read and one written per pixel at its column.
// Reset: synchronous, active low; clears counters, config and pipeline valids. The row
//   memories are not cleared and need no initialization pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module coverage_blur_3x3 (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cb3_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cb3_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [7:0] body_coverage, [15:8] border_coverage
    input  logic [cb3_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [7:0] body_value, [15:8] border_value, [25:16] out_row, [35:26] out_col, rest zero
    output logic [cb3_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast
);
    import cb3_pkg::*;

    // configuration
    logic [CFG_W-1:0] r_image_width;
    logic [CFG_W-1:0] r_image_height;
    logic             r_blur_enable;
    logic             r_border_plane;
    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;

    // input side
    logic               s_accept;
    logic [COORD_W-1:0] r_row_cnt;
    logic [COORD_W-1:0] r_col_cnt;
    logic [CFG_W-1:0]   row_ext;
    logic [CFG_W-1:0]   col_ext;
    logic [CFG_W-1:0]   row_nxt;
    logic [CFG_W-1:0]   col_nxt;
    logic               last_col;
    logic               last_row;
    logic               blur_here;
    t_pixel             in_px;

    // row memories: even rows and odd rows
    logic [PX_W-1:0] r_line_even [MAX_WIDTH];
    logic [PX_W-1:0] r_line_odd  [MAX_WIDTH];
    logic [PX_W-1:0] r_rd_even;
    logic [PX_W-1:0] r_rd_odd;

    // stage 1
    logic             r_s1_valid;
    t_stage           r_s1;
    logic             s1_fire;
    t_pixel           rd_top;
    t_pixel           rd_mid;
    logic [PIX_W-1:0] new_top;
    logic [PIX_W-1:0] new_mid;
    logic [PIX_W-1:0] new_bot;
    logic [PIX_W-1:0] r_win_top [2];
    logic [PIX_W-1:0] r_win_mid [2];
    logic [PIX_W-1:0] r_win_bot [2];
    logic [SUM_W-1:0] blur_sum;
    logic [PIX_W-1:0] blur_byte;
    t_pixel           r_prev_mid;
    t_pixel           r_prev_px;
    t_pixel           v0;
    logic [3:0]       n_out_mask;
    logic             row_ge1;
    logic             col_ge1;

    // output register
    logic [3:0]         r_out_mask;
    logic [COORD_W-1:0] r_out_row;
    logic [COORD_W-1:0] r_out_col;
    t_pixel             r_out_v0;
    t_pixel             r_out_v1;
    t_pixel             r_out_v2;
    t_pixel             r_out_v3;
    t_pixel             out_val;
    logic               out_row_cur;
    logic               out_col_cur;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               out_free;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_W'(1);
            r_image_height <= CFG_W'(1);
            r_blur_enable  <= 1'b0;
            r_border_plane <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                REG_BLUR_ENABLE:  r_blur_enable  <= i_cfg_data[0];
                REG_BORDER_PLANE: r_border_plane <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_eff = clamp_size(r_image_width, CFG_W'(MAX_WIDTH));
    assign h_eff = clamp_size(r_image_height, CFG_W'(MAX_HEIGHT));

    // ---------------- input and raster position ----------------
    assign s_accept = i_s_tvalid && o_s_tready;
    assign in_px    = t_pixel'(i_s_tdata);
    assign row_ext  = {1'b0, r_row_cnt};
    assign col_ext  = {1'b0, r_col_cnt};
    assign row_nxt  = row_ext + CFG_W'(1);
    assign col_nxt  = col_ext + CFG_W'(1);
    assign last_col = col_nxt >= w_eff;
    assign last_row = row_nxt >= h_eff;

    // the pixel one up and one left is interior and its window completes here
    assign blur_here = r_blur_enable && (r_row_cnt >= COORD_W'(2)) && (row_nxt <= h_eff)
                    && (r_col_cnt >= COORD_W'(2)) && (col_nxt <= w_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_col_cnt <= '0;
        end else if (s_accept) begin
            if (last_col) begin
                r_col_cnt <= '0;
                r_row_cnt <= last_row ? '0 : row_nxt[COORD_W-1:0];
            end else begin
                r_col_cnt <= col_nxt[COORD_W-1:0];
            end
        end
    end

    // read-first: the slot of the current row returns the row two above
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_rd_even <= r_line_even[r_col_cnt];
            if (!r_row_cnt[0]) begin
                r_line_even[r_col_cnt] <= i_s_tdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_rd_odd <= r_line_odd[r_col_cnt];
            if (r_row_cnt[0]) begin
                r_line_odd[r_col_cnt] <= i_s_tdata;
            end
        end
    end

    // ---------------- stage 1: window and result bundle ----------------
    assign out_free   = (r_out_mask == '0) || (o_m_tvalid && i_m_tready && o_m_tlast);
    assign s1_fire    = r_s1_valid && out_free;
    assign o_s_tready = !r_s1_valid || s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1.row      <= r_row_cnt;
            r_s1.col      <= r_col_cnt;
            r_s1.last_col <= last_col;
            r_s1.last_row <= last_row;
            r_s1.blur     <= blur_here;
            r_s1.px       <= in_px;
        end
    end

    assign rd_top  = t_pixel'(r_s1.row[0] ? r_rd_odd : r_rd_even);
    assign rd_mid  = t_pixel'(r_s1.row[0] ? r_rd_even : r_rd_odd);
    assign new_top = plane_of(rd_top, r_border_plane);
    assign new_mid = plane_of(rd_mid, r_border_plane);
    assign new_bot = plane_of(r_s1.px, r_border_plane);

    assign blur_sum = SUM_W'(r_win_top[0]) + (SUM_W'(r_win_top[1]) << 1) + SUM_W'(new_top)
                    + (SUM_W'(r_win_mid[0]) << 1) + (SUM_W'(r_win_mid[1]) << 2)
                    + (SUM_W'(new_mid) << 1)
                    + SUM_W'(r_win_bot[0]) + (SUM_W'(r_win_bot[1]) << 1) + SUM_W'(new_bot);
    assign blur_byte = blur_sum[SUM_W-1:4];

    always_comb begin
        v0 = r_prev_mid;
        if (r_s1.blur) begin
            if (r_border_plane) begin
                v0.border = blur_byte;
            end else begin
                v0.body = blur_byte;
            end
        end
    end

    assign row_ge1 = r_s1.row != '0;
    assign col_ge1 = r_s1.col != '0;
    // bit order is raster order: up-left, up, left, here
    assign n_out_mask = {r_s1.last_row && r_s1.last_col,
                         r_s1.last_row && col_ge1,
                         row_ge1 && r_s1.last_col,
                         row_ge1 && col_ge1};

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_win_top[0] <= r_win_top[1];
            r_win_top[1] <= new_top;
            r_win_mid[0] <= r_win_mid[1];
            r_win_mid[1] <= new_mid;
            r_win_bot[0] <= r_win_bot[1];
            r_win_bot[1] <= new_bot;
            r_prev_mid   <= rd_mid;
            r_prev_px    <= r_s1.px;
            r_out_row    <= r_s1.row;
            r_out_col    <= r_s1.col;
            r_out_v0     <= v0;
            r_out_v1     <= rd_mid;
            r_out_v2     <= r_prev_px;
            r_out_v3     <= r_s1.px;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_mask <= '0;
        end else if (s1_fire) begin
            r_out_mask <= n_out_mask;
        end else if (o_m_tvalid && i_m_tready) begin
            r_out_mask <= r_out_mask & (r_out_mask - 4'd1);
        end
    end

    always_comb begin
        if (r_out_mask[0]) begin
            out_val     = r_out_v0;
            out_row_cur = 1'b0;
            out_col_cur = 1'b0;
        end else if (r_out_mask[1]) begin
            out_val     = r_out_v1;
            out_row_cur = 1'b0;
            out_col_cur = 1'b1;
        end else if (r_out_mask[2]) begin
            out_val     = r_out_v2;
            out_row_cur = 1'b1;
            out_col_cur = 1'b0;
        end else begin
            out_val     = r_out_v3;
            out_row_cur = 1'b1;
            out_col_cur = 1'b1;
        end
    end

    assign out_row = out_row_cur ? r_out_row : r_out_row - COORD_W'(1);
    assign out_col = out_col_cur ? r_out_col : r_out_col - COORD_W'(1);

    assign o_m_tvalid = r_out_mask != '0;
    assign o_m_tlast  = (r_out_mask & (r_out_mask - 4'd1)) == '0;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, out_col, out_row, out_val.border, out_val.body};

    // ---------------- assertions ----------------
    `ASSERT_NEXT(a_burst_continues, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast, o_m_tvalid, "results of one pixel broken up")
    `ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, r_s1_valid && !s1_fire, r_s1_valid && $stable(r_s1), "stalled stage 1 item lost")
    `ASSERT_PROP(a_blur_interior, i_clk, i_rst_n, r_s1_valid && r_s1.blur |-> r_s1.row >= COORD_W'(2) && r_s1.col >= COORD_W'(2), "blur flagged on an edge pixel")

endmodule

// ===== tb/coverage_blur_3x3_test.sv =====
`timescale 1ns / 1ps

module coverage_blur_3x3_test;
    import cb3_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0]   body;
        logic [PIX_W-1:0]   border;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } blur_px_t;

    typedef enum logic {
        STEP_CFG,
        STEP_PIX
    } step_kind_e;

    typedef struct packed {
        step_kind_e       kind;
        t_reg_idx         idx;
        logic [CFG_W-1:0] val;
        t_pixel           px;
        logic             typed;
        blur_px_t         want;
    } dir_step_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;

    coverage_blur_3x3 u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // blur predictor state
    t_pixel           row_mem [0:2*MAX_WIDTH-1];
    logic [PIX_W-1:0] nbhd [0:8];
    int               row_at = 0;
    int               col_at = 0;
    logic [CFG_W-1:0] reg_width = CFG_W'(1);
    logic [CFG_W-1:0] reg_height = CFG_W'(1);
    logic             reg_blur = 1'b0;
    logic             reg_border = 1'b0;

    blur_px_t    released_pixels [$];
    blur_px_t    expected_pixels [$];
    int          mismatch_count = 0;
    int          pixels_accepted = 0;
    int          burst_left = 0;
    dir_step_t   plan [0:33];

    initial begin
        foreach (row_mem[i]) row_mem[i] = '0;
        foreach (nbhd[i]) nbhd[i] = '0;
    end

    function automatic int eff_size(input logic [CFG_W-1:0] v, input int cap);
        if (v == '0) return 1;
        if (int'(v) > cap) return cap;
        return int'(v);
    endfunction

    function automatic logic [PIX_W-1:0] pick_plane(input t_pixel p);
        return reg_border ? p.border : p.body;
    endfunction

    // Results released by one accepted pixel land in released_pixels.
    function automatic void predict_blur_pixel(input t_pixel px);
        int       w;
        int       h;
        int       ar;
        int       ac;
        int       nr;
        int       nc;
        int       sum;
        int       rows [2];
        int       cols [2];
        bit       blur;
        bit       last_c;
        bit       last_r;
        t_pixel   v;
        blur_px_t res;
        w = eff_size(reg_width, MAX_WIDTH);
        h = eff_size(reg_height, MAX_HEIGHT);
        ar = row_at;
        ac = col_at;
        blur = reg_blur && w >= 3 && h >= 3;
        last_c = (ac + 1 >= w);
        last_r = (ar + 1 >= h);

        for (int i = 0; i < 3; i++) begin
            nbhd[i*3] = nbhd[i*3+1];
            nbhd[i*3+1] = nbhd[i*3+2];
        end
        nbhd[2] = pick_plane(row_mem[(ar % 2) * MAX_WIDTH + ac]);
        nbhd[5] = pick_plane(row_mem[((ar + 1) % 2) * MAX_WIDTH + ac]);
        nbhd[8] = pick_plane(px);
        row_mem[(ar % 2) * MAX_WIDTH + ac] = px;

        nr = 0;
        nc = 0;
        if (ar >= 1) begin
            rows[nr] = ar - 1;
            nr++;
        end
        if (last_r) begin
            rows[nr] = ar;
            nr++;
        end
        if (ac >= 1) begin
            cols[nc] = ac - 1;
            nc++;
        end
        if (last_c) begin
            cols[nc] = ac;
            nc++;
        end

        released_pixels.delete();
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
                v = row_mem[(rows[i] % 2) * MAX_WIDTH + cols[j]];
                res.body = v.body;
                res.border = v.border;
                res.row = COORD_W'(rows[i]);
                res.col = COORD_W'(cols[j]);
                res.last = 1'b0;
                // only the interior pixel whose window just closed gets filtered
                if (blur && rows[i] + 1 == ar && cols[j] + 1 == ac && rows[i] >= 1 &&
                    rows[i] + 2 <= h && cols[j] >= 1 && cols[j] + 2 <= w) begin
                    sum = int'(nbhd[0]) + 2 * nbhd[1] + nbhd[2]
                        + 2 * nbhd[3] + 4 * nbhd[4] + 2 * nbhd[5]
                        + nbhd[6] + 2 * nbhd[7] + nbhd[8];
                    if (reg_border) res.border = PIX_W'(sum >> 4);
                    else res.body = PIX_W'(sum >> 4);
                end
                released_pixels = {released_pixels, res};
            end
        end
        if (released_pixels.size() > 0)
            released_pixels[released_pixels.size()-1].last = 1'b1;

        if (last_c) begin
            col_at = 0;
            row_at = last_r ? 0 : ar + 1;
        end else begin
            col_at = ac + 1;
        end
    endfunction

    // Block idle: nothing outstanding, then a wait so that pixels with no result also leave the pipeline.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_setting(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_IMAGE_WIDTH:  reg_width = val;
            REG_IMAGE_HEIGHT: reg_height = val;
            REG_BLUR_ENABLE:  reg_blur = val[0];
            REG_BORDER_PLANE: reg_border = val[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pixel(input t_pixel px, input bit use_typed, input blur_px_t typed_px);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= px;
        do @(posedge i_clk); while (!o_s_tready);
        predict_blur_pixel(px);
        if (use_typed) begin
            expected_pixels = {expected_pixels, typed_px};
        end else begin
            expected_pixels = {expected_pixels, released_pixels};
        end
        pixels_accepted++;
    endtask

    // One frame; with twist set and more than one pixel, one register changes partway through the frame.
    task automatic run_frame(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val,
                             input logic blur_on, input logic plane_sel, input bit twist,
                             output int sent);
        int     k;
        int     w_e;
        int     h_e;
        t_pixel px;
        wait_drained();
        write_setting(REG_IMAGE_WIDTH, w_val);
        write_setting(REG_IMAGE_HEIGHT, h_val);
        write_setting(REG_BLUR_ENABLE, {{(CFG_W-1){1'b0}}, blur_on});
        write_setting(REG_BORDER_PLANE, {{(CFG_W-1){1'b0}}, plane_sel});
        w_e = eff_size(w_val, MAX_WIDTH);
        h_e = eff_size(h_val, MAX_HEIGHT);
        k = (twist && w_e * h_e > 1) ? $urandom_range(1, w_e * h_e - 1) : -1;
        sent = 0;
        do begin
            case ($urandom_range(0, 7))
                0: px = '0;
                1: px = '1;
                2: px = 16'h00ff;
                3: px = 16'hff00;
                default: px = 16'($urandom);
            endcase
            send_pixel(px, 1'b0, '0);
            sent++;
            if (sent == k) begin
                wait_drained();
                // plane flip, width shrink or height shrink; never grow the width here
                case ($urandom_range(0, 2))
                    0: write_setting(REG_BORDER_PLANE, {{(CFG_W-1){1'b0}}, ~reg_border});
                    1: write_setting(REG_IMAGE_WIDTH, CFG_W'($urandom_range(0, w_e)));
                    default: write_setting(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, h_e)));
                endcase
            end
        end while (row_at != 0 || col_at != 0);
    endtask

    // output side: stall pattern of its own plus one long hold-off
    logic [15:0] rx_pat = 16'hffff;
    int unsigned rx_cyc = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always @(posedge i_clk) begin
        rx_cyc <= rx_cyc + 1;
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (!hold_done && pixels_accepted >= 60) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            i_m_tready <= 1'b0;
        end else begin
            if (rx_cyc % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0: rx_pat <= '1;
                    1: rx_pat <= 16'($urandom);
                    2: rx_pat <= 16'($urandom) | 16'($urandom);
                    default: rx_pat <= 16'($urandom) & 16'($urandom);
                endcase
            end
            i_m_tready <= rx_pat[rx_cyc % 16];
        end
    end

    always @(posedge i_clk) begin
        blur_px_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_pixels.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result transaction, got %h last %b",
                         $time, o_m_tdata, o_m_tlast);
            end else begin
                want = expected_pixels.pop_front();
                if (o_m_tdata[7:0] !== want.body || o_m_tdata[15:8] !== want.border ||
                    o_m_tdata[25:16] !== want.row || o_m_tdata[35:26] !== want.col ||
                    o_m_tdata[OUT_TDATA_W-1:OUT_FIELD_W] !== '0 ||
                    o_m_tlast !== want.last) begin
                    mismatch_count++;
                    $display({"%0t: mismatch: expected body %h border %h row %0d col %0d ",
                              "last %b, actual body %h border %h row %0d col %0d last %b ",
                              "pad %h"},
                             $time, want.body, want.border, want.row, want.col, want.last,
                             o_m_tdata[7:0], o_m_tdata[15:8], o_m_tdata[25:16],
                             o_m_tdata[35:26], o_m_tlast,
                             o_m_tdata[OUT_TDATA_W-1:OUT_FIELD_W]);
                end
            end
        end
    end

    initial begin
        int n;
        int rand_sent;
        rand_sent = 0;
        plan = '{
            // reset settings: 1x1 image, every pixel comes straight back
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'h0000, 1'b1, '{8'h00, 8'h00, 10'd0, 10'd0, 1'b1}},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'hffff, 1'b1, '{8'hff, 8'hff, 10'd0, 10'd0, 1'b1}},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'ha55a, 1'b1, '{8'h5a, 8'ha5, 10'd0, 10'd0, 1'b1}},
            // zero sizes act as one; blur on a 1x1 image passes through
            '{STEP_CFG, REG_IMAGE_WIDTH, 11'd0, 16'h0000, 1'b0, '0},
            '{STEP_CFG, REG_IMAGE_HEIGHT, 11'd0, 16'h0000, 1'b0, '0},
            '{STEP_CFG, REG_BLUR_ENABLE, 11'd1, 16'h0000, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'h3cc3, 1'b1, '{8'hc3, 8'h3c, 10'd0, 10'd0, 1'b1}},
            // 3x3 body plane, largest possible sum at the center
            '{STEP_CFG, REG_IMAGE_WIDTH, 11'd3, 16'h0000, 1'b0, '0},
            '{STEP_CFG, REG_IMAGE_HEIGHT, 11'd3, 16'h0000, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'h00ff, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'h01ff, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'h02ff, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'h04ff, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'h08ff, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'h10ff, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'h20ff, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'h40ff, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'h80ff, 1'b0, '0},
            // 3x3 border plane
            '{STEP_CFG, REG_BORDER_PLANE, 11'd1, 16'h0000, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'hff00, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'h0001, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'hff02, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'h0004, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'hff08, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'h0010, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'hff20, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'h0040, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'hff80, 1'b0, '0},
            // blur on but 2x2: no filtering
            '{STEP_CFG, REG_IMAGE_WIDTH, 11'd2, 16'h0000, 1'b0, '0},
            '{STEP_CFG, REG_IMAGE_HEIGHT, 11'd2, 16'h0000, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'h1234, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'hfedc, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'h00ff, 1'b0, '0},
            '{STEP_PIX, REG_IMAGE_WIDTH, 11'd0, 16'hff00, 1'b0, '0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == STEP_CFG) begin
                wait_drained();
                write_setting(plan[i].idx, plan[i].val);
            end else begin
                send_pixel(plan[i].px, plan[i].typed, plan[i].want);
            end
        end

        while (rand_sent < 130) begin
            run_frame(CFG_W'($urandom_range(0, 8)), CFG_W'($urandom_range(0, 8)),
                      1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 3) == 0, n);
            rand_sent += n;
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("coverage_blur_3x3 regression: pass");
        end else begin
            $display("coverage_blur_3x3 regression: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("coverage_blur_3x3 regression: fail");
        $finish;
    end

endmodule
